// ===== rtl/ray_convex_brush_intersect_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RAY_CONVEX_BRUSH_INTERSECT_ASSERT_SVH
`define RAY_CONVEX_BRUSH_INTERSECT_ASSERT_SVH

// Implication checked on every rising edge, skipped while reset is low.
`define RCBI_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Same, with a fixed clock and reset name.
`define RCBI_ASSERT_STD(lbl, prop, msg) `RCBI_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ===== rtl/rcbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rcbi_pkg
// Types, constants and helpers for the ray / convex brush intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcbi_pkg;

	localparam int MAX_SIDES_DEF = 64;
	localparam int MIN_SIDES     = 4;
	localparam int CFG_IDX_W     = 3;
	localparam int Q_DEPTH       = 4;

	localparam logic [63:0]        SLOPE_EPS = 64'd288230376;
	localparam logic signed [31:0] PARAM_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] PARAM_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORG_X = 3'd0,
		CFG_ORG_Y = 3'd1,
		CFG_ORG_Z = 3'd2,
		CFG_DIR_X = 3'd3,
		CFG_DIR_Y = 3'd4,
		CFG_DIR_Z = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_DIV,
		B_UPD,
		B_FIN,
		B_PT,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] plane_offset;
		logic [15:0]        solid_id;
		logic               last_side;
	} in_item_t;

	typedef struct packed {
		logic               hit_valid;
		logic [15:0]        hit_solid;
		logic [5:0]         hit_face;
		logic [30:0]        hit_distance;
		logic signed [31:0] hit_point_x;
		logic signed [31:0] hit_point_y;
		logic signed [31:0] hit_point_z;
	} out_item_t;

	// plane reduced to slope (Q.58) and signed distance (Q.44)
	typedef struct packed {
		logic signed [63:0] slope;
		logic signed [63:0] sdist;
		logic [15:0]        solid_id;
		logic               last_side;
	} plane_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = PARAM_MAX;
		else if (v < -34'sd2147483648)
			r = PARAM_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rcbi_front.sv =====
// ----------------------------------------------------------------------------
// rcbi_front
// Takes one plane and forms slope and distance with two shared multipliers.
// ----------------------------------------------------------------------------
`default_nettype none

module rcbi_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rcbi_pkg::in_item_t in_data,
	input  wire logic signed [31:0] org [3],
	input  wire logic signed [31:0] dir [3],
	input  wire rcbi_pkg::q_stat_t  q_stat,
	output logic                    q_wr,
	output rcbi_pkg::plane_t        q_wdata
);

	logic               busy_q;
	logic [1:0]         ph_q;
	logic signed [31:0] n_q [3];
	logic [15:0]        id_q;
	logic               last_q;
	logic signed [63:0] ps_s1, pd_s1;
	logic signed [63:0] accs_q, accd_q;
	logic signed [31:0] nsel, dsel, osel;
	logic               accept;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;

	always_comb begin
		case (ph_q)
			2'd0: begin nsel = n_q[0]; dsel = dir[0]; osel = org[0]; end
			2'd1: begin nsel = n_q[1]; dsel = dir[1]; osel = org[1]; end
			default: begin nsel = n_q[2]; dsel = dir[2]; osel = org[2]; end
		endcase
	end

	assign q_wr              = busy_q && (ph_q == 2'd3) && !q_stat.full;
	assign q_wdata.slope     = accs_q + ps_s1;
	assign q_wdata.sdist     = accd_q + pd_s1;
	assign q_wdata.solid_id  = id_q;
	assign q_wdata.last_side = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 2'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			ph_q   <= 2'd0;
		end else if (busy_q) begin
			if (ph_q != 2'd3)
				ph_q <= ph_q + 2'd1;
			else if (!q_stat.full)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q[0] <= in_data.normal_x;
			n_q[1] <= in_data.normal_y;
			n_q[2] <= in_data.normal_z;
			id_q   <= in_data.solid_id;
			last_q <= in_data.last_side;
			accs_q <= '0;
			// offset in Q.44, subtracted up front
			accd_q <= -($signed({{4{in_data.plane_offset[31]}}, in_data.plane_offset, 28'd0}));
		end else if (busy_q && ph_q != 2'd3) begin
			ps_s1 <= (64'(nsel) * 64'(dsel)) >>> 2;
			pd_s1 <= (64'(nsel) * 64'(osel)) >>> 2;
			if (ph_q != 2'd0) begin
				accs_q <= accs_q + ps_s1;
				accd_q <= accd_q + pd_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rcbi_fifo.sv =====
// ----------------------------------------------------------------------------
// rcbi_fifo
// Short plane queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rcbi_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire rcbi_pkg::plane_t  wdata,
	input  wire logic              rd,
	output rcbi_pkg::plane_t       rdata,
	output rcbi_pkg::q_stat_t      stat
);

	localparam int AW = $clog2(rcbi_pkg::Q_DEPTH);

	rcbi_pkg::plane_t mem_q [rcbi_pkg::Q_DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (AW+1)'(rcbi_pkg::Q_DEPTH));
	assign rdata      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rcbi_back.sv =====
// ----------------------------------------------------------------------------
// rcbi_back
// Per-solid slab update: serial divide, entry/exit tracking, hit point.
// ----------------------------------------------------------------------------
`default_nettype none

module rcbi_back #(
	parameter int MAX_SIDES = rcbi_pkg::MAX_SIDES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rcbi_pkg::q_stat_t  q_stat,
	output logic                    q_rd,
	input  wire rcbi_pkg::plane_t   q_rdata,
	input  wire logic signed [31:0] org [3],
	input  wire logic signed [31:0] dir [3],
	output logic                    out_valid,
	input  wire logic               out_stall,
	output rcbi_pkg::out_item_t     out_data
);

	localparam int SCW = $clog2(MAX_SIDES + 1);

	rcbi_pkg::back_state_t state_q, state_d;

	rcbi_pkg::plane_t   ent_q;
	logic               take_q;
	logic [SCW-1:0]     side_q, idx_q;
	logic signed [31:0] enter_q, leave_q;
	logic [5:0]         face_q;
	logic               rej_q;
	logic [63:0]        d_q, r_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	logic               neg_q, sat_q;
	logic               hit_q;
	logic [30:0]        dist_q;
	logic [1:0]         ph_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] pt_q [3];
	logic               out_load;

	logic [63:0]        mag_s, mag_d;
	logic               near;
	logic [64:0]        r2;
	logic               ge;
	logic signed [31:0] t, ne, nl;
	logic               hit_w;
	logic signed [31:0] dsel;

	assign mag_s = ent_q.slope[63] ? 64'(-ent_q.slope) : 64'(ent_q.slope);
	assign mag_d = ent_q.sdist[63] ? 64'(-ent_q.sdist) : 64'(ent_q.sdist);
	assign near  = mag_s < rcbi_pkg::SLOPE_EPS;
	assign r2    = {r_q, 1'b0};
	assign ge    = r2 >= {1'b0, d_q};

	always_comb begin
		if (sat_q)
			t = neg_q ? rcbi_pkg::PARAM_MIN : rcbi_pkg::PARAM_MAX;
		else
			t = neg_q ? -$signed(quo_q) : $signed(quo_q);
		ne = enter_q;
		nl = leave_q;
		if (ent_q.slope[63]) begin
			if (t > enter_q)
				ne = t;
		end else if (t < leave_q) begin
			nl = t;
		end
	end

	assign hit_w = !rej_q && (side_q >= SCW'(rcbi_pkg::MIN_SIDES))
		&& (enter_q <= leave_q) && !leave_q[31];

	always_comb begin
		case (ph_q)
			2'd0: dsel = dir[0];
			2'd1: dsel = dir[1];
			default: dsel = dir[2];
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcbi_pkg::B_IDLE: if (!q_stat.empty) state_d = rcbi_pkg::B_LOAD;
			rcbi_pkg::B_LOAD: begin
				if (!take_q || near)
					state_d = rcbi_pkg::B_FIN;
				else if ({1'b0, mag_d} >= {mag_s, 1'b0})
					state_d = rcbi_pkg::B_UPD;
				else
					state_d = rcbi_pkg::B_DIV;
			end
			rcbi_pkg::B_DIV:  if (cnt_q == 5'd29) state_d = rcbi_pkg::B_UPD;
			rcbi_pkg::B_UPD:  state_d = rcbi_pkg::B_FIN;
			rcbi_pkg::B_FIN: begin
				if (!ent_q.last_side)
					state_d = rcbi_pkg::B_IDLE;
				else if (hit_w)
					state_d = rcbi_pkg::B_PT;
				else
					state_d = rcbi_pkg::B_OUT;
			end
			rcbi_pkg::B_PT:   if (ph_q == 2'd3) state_d = rcbi_pkg::B_OUT;
			rcbi_pkg::B_OUT:  if (!out_valid || !out_stall) state_d = rcbi_pkg::B_IDLE;
			default:          state_d = rcbi_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_rd     = (state_q == rcbi_pkg::B_IDLE) && !q_stat.empty;
		out_load = (state_q == rcbi_pkg::B_OUT) && (!out_valid || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rcbi_pkg::B_IDLE;
			out_valid <= 1'b0;
			side_q    <= '0;
			enter_q   <= rcbi_pkg::PARAM_MIN;
			leave_q   <= rcbi_pkg::PARAM_MAX;
			face_q    <= '0;
			rej_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;

			if (q_rd && side_q < SCW'(MAX_SIDES))
				side_q <= side_q + 1'b1;
			if (state_q == rcbi_pkg::B_LOAD && take_q && near && !ent_q.sdist[63]
					&& ent_q.sdist != '0)
				rej_q <= 1'b1;
			if (state_q == rcbi_pkg::B_UPD) begin
				enter_q <= ne;
				leave_q <= nl;
				if (ne != enter_q)
					face_q <= 6'(idx_q);
				if (ne > nl)
					rej_q <= 1'b1;
			end
			if (out_load) begin
				side_q  <= '0;
				enter_q <= rcbi_pkg::PARAM_MIN;
				leave_q <= rcbi_pkg::PARAM_MAX;
				face_q  <= '0;
				rej_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rcbi_pkg::B_IDLE: begin
				if (q_rd) begin
					ent_q  <= q_rdata;
					idx_q  <= side_q;
					take_q <= (side_q < SCW'(MAX_SIDES)) && !rej_q;
				end
			end
			rcbi_pkg::B_LOAD: begin
				neg_q <= (ent_q.sdist[63] == ent_q.slope[63]);
				d_q   <= mag_s;
				sat_q <= ({1'b0, mag_d} >= {mag_s, 1'b0});
				cnt_q <= '0;
				if (mag_d >= mag_s) begin
					quo_q <= 32'd1;
					r_q   <= mag_d - mag_s;
				end else begin
					quo_q <= 32'd0;
					r_q   <= mag_d;
				end
			end
			rcbi_pkg::B_DIV: begin
				r_q   <= ge ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q + 5'd1;
			end
			rcbi_pkg::B_FIN: begin
				hit_q  <= hit_w;
				dist_q <= enter_q[31] ? 31'd0 : enter_q[30:0];
				ph_q   <= 2'd0;
			end
			rcbi_pkg::B_PT: begin
				if (ph_q != 2'd3)
					prod_s1 <= 64'(dsel) * 64'($signed({1'b0, dist_q}));
				if (ph_q != 2'd0)
					pt_q[ph_q - 2'd1] <= rcbi_pkg::sat32(34'(org[ph_q - 2'd1])
						+ 34'(prod_s1 >>> 30));
				ph_q <= ph_q + 2'd1;
			end
			rcbi_pkg::B_OUT: begin
				if (out_load) begin
					out_data.hit_valid    <= hit_q;
					out_data.hit_solid    <= ent_q.solid_id;
					out_data.hit_face     <= hit_q ? face_q : 6'd0;
					out_data.hit_distance <= hit_q ? dist_q : 31'd0;
					out_data.hit_point_x  <= hit_q ? pt_q[0] : 32'sd0;
					out_data.hit_point_y  <= hit_q ? pt_q[1] : 32'sd0;
					out_data.hit_point_z  <= hit_q ? pt_q[2] : 32'sd0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ray_convex_brush_intersect.sv =====
// Front: three shared multiply steps and a queue push per plane; it takes the
// next plane only after the push, which waits while the queue is full. Back:
// a load step, a serial divide (one quotient bit per cycle) unless the result
// saturates, then update and finish; skipped and near-parallel planes go
// straight to finish. A last plane adds the hit point on a hit, then the result.
// Reset clears the ray registers to zero and the per-solid state.
// ----------------------------------------------------------------------------
// ray_convex_brush_intersect
// Ray against convex solid, one bounding plane per transfer (slab method).
// ----------------------------------------------------------------------------
`default_nettype none

module ray_convex_brush_intersect #(
	parameter int MAX_SIDES = rcbi_pkg::MAX_SIDES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rcbi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire rcbi_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rcbi_pkg::out_item_t                 out_data
);

	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];

	rcbi_pkg::q_stat_t q_stat;
	rcbi_pkg::plane_t  q_wdata, q_rdata;
	logic              q_wr, q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '{default: '0};
			dir_q <= '{default: '0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcbi_pkg::CFG_ORG_X: org_q[0] <= cfg_data;
				rcbi_pkg::CFG_ORG_Y: org_q[1] <= cfg_data;
				rcbi_pkg::CFG_ORG_Z: org_q[2] <= cfg_data;
				rcbi_pkg::CFG_DIR_X: dir_q[0] <= cfg_data;
				rcbi_pkg::CFG_DIR_Y: dir_q[1] <= cfg_data;
				rcbi_pkg::CFG_DIR_Z: dir_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcbi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.org      (org_q),
		.dir      (dir_q),
		.q_stat   (q_stat),
		.q_wr     (q_wr),
		.q_wdata  (q_wdata)
	);

	rcbi_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	rcbi_back #(
		.MAX_SIDES (MAX_SIDES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rd      (q_rd),
		.q_rdata   (q_rdata),
		.org       (org_q),
		.dir       (dir_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/rcbi_checker.sv =====
// ----------------------------------------------------------------------------
// rcbi_checker
// Port-level checks on the intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_convex_brush_intersect_assert.svh"

module rcbi_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire rcbi_pkg::out_item_t out_data
);

	`RCBI_ASSERT_STD(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	`RCBI_ASSERT_STD(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled result changed")

	`RCBI_ASSERT_STD(a_miss_zero, out_valid && !out_data.hit_valid |-> out_data.hit_face == '0 && out_data.hit_distance == '0 && out_data.hit_point_x == '0 && out_data.hit_point_y == '0 && out_data.hit_point_z == '0, "miss carries nonzero fields")

	`RCBI_ASSERT_STD(a_front_busy, in_valid && !in_stall |=> in_stall, "front took two planes back to back")

endmodule

bind ray_convex_brush_intersect rcbi_checker u_rcbi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

// ===== sim/ray_convex_brush_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// ray_convex_brush_intersect_tb
// Streams convex solids plane by plane under several ray settings, predicts
// every hit/miss record in fixed point and compares each output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_convex_brush_intersect_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG  = 5000;
	localparam int SETTLE    = 200;
	localparam int PHASE_LEN = 130;
	localparam logic signed [31:0] ONE_N = 32'sh4000_0000;  // 1.0 in Q2.30
	localparam logic signed [31:0] UNIT  = 32'sh0001_0000;  // 1.0 in Q16.16

	class brush_hit_tracker;
		logic signed [31:0] ray [6];
		int        enter_t, leave_t;
		logic [5:0] enter_face;
		int        sides;
		bit        dropped;
		rcbi_pkg::out_item_t pending_hits[$];
		int        mismatches, results, hits, planes;

		function new();
			foreach (ray[i]) ray[i] = '0;
			clear_solid();
		endfunction

		function void clear_solid();
			enter_t = rcbi_pkg::PARAM_MIN;
			leave_t = rcbi_pkg::PARAM_MAX;
			enter_face = '0;
			sides = 0;
			dropped = 0;
		endfunction

		function void set_reg(rcbi_pkg::cfg_idx_t idx, logic signed [31:0] v);
			ray[idx] = v;
		endfunction

		function int cross_param(longint d, longint s);
			longint unsigned n, dv, q, r, lim;
			bit neg;
			longint v;
			n = d < 0 ? -d : d;
			dv = s < 0 ? -s : s;
			neg = (d < 0) == (s < 0);
			q = n / dv;
			r = n % dv;
			if (q >= 2)
				return neg ? rcbi_pkg::PARAM_MIN : rcbi_pkg::PARAM_MAX;
			for (int i = 0; i < 30; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= dv) begin
					r = r - dv;
					q = q | 1;
				end
			end
			lim = neg ? 64'd2147483648 : 64'd2147483647;
			if (q > lim)
				q = lim;
			v = neg ? -longint'(q) : longint'(q);
			return int'(v);
		endfunction

		function void apply_plane(rcbi_pkg::in_item_t it, int idx);
			longint slope, sdist, a;
			int t;
			slope = ((longint'(it.normal_x) * longint'(ray[rcbi_pkg::CFG_DIR_X])) >>> 2)
			      + ((longint'(it.normal_y) * longint'(ray[rcbi_pkg::CFG_DIR_Y])) >>> 2)
			      + ((longint'(it.normal_z) * longint'(ray[rcbi_pkg::CFG_DIR_Z])) >>> 2);
			sdist = ((longint'(it.normal_x) * longint'(ray[rcbi_pkg::CFG_ORG_X])) >>> 2)
			      + ((longint'(it.normal_y) * longint'(ray[rcbi_pkg::CFG_ORG_Y])) >>> 2)
			      + ((longint'(it.normal_z) * longint'(ray[rcbi_pkg::CFG_ORG_Z])) >>> 2)
			      - longint'(it.plane_offset) * 64'sd268435456;
			a = slope < 0 ? -slope : slope;
			if (a < longint'(rcbi_pkg::SLOPE_EPS)) begin
				if (sdist > 0)
					dropped = 1;
				return;
			end
			t = cross_param(sdist, slope);
			if (slope < 0) begin
				if (t > enter_t) begin
					enter_t = t;
					enter_face = idx[5:0];
				end
			end else if (t < leave_t) begin
				leave_t = t;
			end
			if (enter_t > leave_t)
				dropped = 1;
		endfunction

		function logic signed [31:0] point_coord(logic signed [31:0] org,
				logic signed [31:0] dir, longint d);
			longint v;
			v = longint'(org) + ((longint'(dir) * d) >>> 30);
			if (v > longint'(rcbi_pkg::PARAM_MAX)) v = rcbi_pkg::PARAM_MAX;
			if (v < longint'(rcbi_pkg::PARAM_MIN)) v = rcbi_pkg::PARAM_MIN;
			return v[31:0];
		endfunction

		// accepted plane: advance the solid, queue a record on the last one
		function void take_plane(rcbi_pkg::in_item_t it);
			rcbi_pkg::out_item_t o;
			longint d;
			planes++;
			if (sides < rcbi_pkg::MAX_SIDES_DEF) begin
				if (!dropped)
					apply_plane(it, sides);
				sides++;
			end
			if (!it.last_side)
				return;
			o = '0;
			o.hit_solid = it.solid_id;
			if (!dropped && sides >= rcbi_pkg::MIN_SIDES && enter_t <= leave_t
					&& leave_t >= 0) begin
				d = enter_t > 0 ? enter_t : 0;
				o.hit_valid = 1'b1;
				o.hit_face = enter_face;
				o.hit_distance = d[30:0];
				o.hit_point_x = point_coord(ray[rcbi_pkg::CFG_ORG_X],
					ray[rcbi_pkg::CFG_DIR_X], d);
				o.hit_point_y = point_coord(ray[rcbi_pkg::CFG_ORG_Y],
					ray[rcbi_pkg::CFG_DIR_Y], d);
				o.hit_point_z = point_coord(ray[rcbi_pkg::CFG_ORG_Z],
					ray[rcbi_pkg::CFG_DIR_Z], d);
			end
			pending_hits.push_back(o);
			clear_solid();
		endfunction

		function void match_hit(rcbi_pkg::out_item_t got);
			rcbi_pkg::out_item_t e;
			string bad;
			results++;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result %h", $realtime, got);
				return;
			end
			e = pending_hits.pop_front();
			if (e.hit_valid) hits++;
			bad = "";
			if (got.hit_valid !== e.hit_valid) bad = {bad, " hit_valid"};
			if (got.hit_solid !== e.hit_solid) bad = {bad, " hit_solid"};
			if (got.hit_face !== e.hit_face) bad = {bad, " hit_face"};
			if (got.hit_distance !== e.hit_distance) bad = {bad, " hit_distance"};
			if (got.hit_point_x !== e.hit_point_x) bad = {bad, " hit_point_x"};
			if (got.hit_point_y !== e.hit_point_y) bad = {bad, " hit_point_y"};
			if (got.hit_point_z !== e.hit_point_z) bad = {bad, " hit_point_z"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch in%s\n  expected %h\n  actual   %h",
						$realtime, bad, e, got);
			end
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      cfg_we = 0;
	logic [rcbi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic      in_valid = 0;
	logic      in_stall;
	rcbi_pkg::in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 0;
	rcbi_pkg::out_item_t out_data;

	brush_hit_tracker hits_sb = new();
	int  sent;
	bit  sender_calm;
	int  idle_cycles;
	bit  held;
	int  hold_left;

	ray_convex_brush_intersect dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			hits_sb.match_hit(out_data);
		if ((out_valid && !out_stall) || (in_valid && !in_stall))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG);
			$display("ray_convex_brush_intersect_tb: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, one calm stretch
	always @(posedge clk) begin
		if (!held && hits_sb.results >= 12) begin
			held = 1;
			hold_left = 700;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hits_sb.results >= 40 && hits_sb.results < 80) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 32);
		end
	end

	task automatic write_reg(rcbi_pkg::cfg_idx_t idx, logic signed [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		hits_sb.set_reg(idx, v);
	endtask

	task automatic set_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
		in_valid <= 1'b0;
		while (hits_sb.pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(rcbi_pkg::CFG_ORG_X, ox);
		write_reg(rcbi_pkg::CFG_ORG_Y, oy);
		write_reg(rcbi_pkg::CFG_ORG_Z, oz);
		write_reg(rcbi_pkg::CFG_DIR_X, dx);
		write_reg(rcbi_pkg::CFG_DIR_Y, dy);
		write_reg(rcbi_pkg::CFG_DIR_Z, dz);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_plane(logic signed [31:0] nx, ny, nz, off,
			logic [15:0] id, logic last);
		rcbi_pkg::in_item_t it;
		it = '{nx, ny, nz, off, id, last};
		while (!sender_calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		hits_sb.take_plane(it);
		sent++;
	endtask

	// axis box around a point on the ray; planes in random order, sometimes followed by random extra planes
	task automatic send_box(logic [15:0] id);
		longint k, c[3], h;
		logic signed [31:0] n[3];
		int order[6];
		int extra;
		k = longint'($urandom_range(60 * 65536)) - 10 * 65536;
		for (int a = 0; a < 3; a++)
			c[a] = longint'(hits_sb.ray[a]) + ((longint'(hits_sb.ray[3 + a]) * k) >>> 30);
		foreach (order[i]) order[i] = i;
		order.shuffle();
		extra = ($urandom_range(9) == 0) ? $urandom_range(3) : 0;
		for (int i = 0; i < 6 + extra; i++) begin
			if (i < 6) begin
				int a, s;
				a = order[i] / 2;
				s = order[i] % 2;
				h = longint'($urandom_range(1, 20 * 65536));
				n = '{0, 0, 0};
				n[a] = s ? -ONE_N : ONE_N;
				send_plane(n[0], n[1], n[2], s ? 32'(h - c[a]) : 32'(c[a] + h),
					id, i == 5 + extra);
			end else begin
				send_plane($urandom, $urandom, $urandom, $urandom, id, i == 5 + extra);
			end
		end
	endtask

	task automatic send_noise(int cnt);
		logic [15:0] id;
		id = 16'($urandom);
		for (int i = 0; i < cnt; i++)
			send_plane($urandom, $urandom, $urandom, $urandom,
				($urandom_range(7) == 0) ? 16'($urandom) : id, i == cnt - 1);
	endtask

	task automatic random_phase();
		int target;
		int r;
		target = sent + PHASE_LEN;
		while (sent < target) begin
			r = $urandom_range(99);
			if (r < 65) send_box(16'($urandom));
			else if (r < 95) send_noise($urandom_range(1, 8));
			else send_noise($urandom_range(65, 70));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// origin zero, direction +x
		sender_calm = 0;
		set_ray(0, 0, 0, ONE_N, 0, 0);
		// box ahead: entered through the -x face
		send_plane(ONE_N, 0, 0, 4 * UNIT, 16'h0001, 0);
		send_plane(-ONE_N, 0, 0, -2 * UNIT, 16'h0001, 0);
		send_plane(0, ONE_N, 0, UNIT, 16'h0001, 0);
		send_plane(0, -ONE_N, 0, UNIT, 16'h0001, 1);
		// origin inside: zero distance
		send_plane(ONE_N, 0, 0, UNIT, 16'h0002, 0);
		send_plane(-ONE_N, 0, 0, UNIT, 16'h0002, 0);
		send_plane(0, ONE_N, 0, UNIT, 16'h0002, 0);
		send_plane(0, -ONE_N, 0, UNIT, 16'h0002, 1);
		// box behind the origin: exit is negative
		send_plane(ONE_N, 0, 0, -2 * UNIT, 16'h0003, 0);
		send_plane(-ONE_N, 0, 0, 4 * UNIT, 16'h0003, 0);
		send_plane(0, ONE_N, 0, UNIT, 16'h0003, 0);
		send_plane(0, -ONE_N, 0, UNIT, 16'h0003, 1);
		// only three planes
		send_plane(ONE_N, 0, 0, 4 * UNIT, 16'h0004, 0);
		send_plane(-ONE_N, 0, 0, -2 * UNIT, 16'h0004, 0);
		send_plane(0, ONE_N, 0, UNIT, 16'h0004, 1);
		// parallel plane with origin outside, then more planes ignored
		send_plane(0, ONE_N, 0, -UNIT, 16'h0005, 0);
		send_plane(ONE_N, 0, 0, 4 * UNIT, 16'h0005, 0);
		send_plane(-ONE_N, 0, 0, -2 * UNIT, 16'h0005, 0);
		send_plane(0, -ONE_N, 0, UNIT, 16'h0005, 1);
		// saturated entry at the reset value, field extremes, mixed ids
		send_plane(-ONE_N, 0, 0, rcbi_pkg::PARAM_MAX, 16'h0000, 0);
		send_plane(rcbi_pkg::PARAM_MAX, rcbi_pkg::PARAM_MIN, rcbi_pkg::PARAM_MAX,
			rcbi_pkg::PARAM_MIN, 16'hFFFF, 0);
		send_plane(rcbi_pkg::PARAM_MIN, rcbi_pkg::PARAM_MAX, rcbi_pkg::PARAM_MIN,
			rcbi_pkg::PARAM_MAX, 16'h1234, 0);
		send_plane(ONE_N, 0, 0, rcbi_pkg::PARAM_MAX, 16'hFFFF, 1);

		set_ray($urandom_range(0, 16 * 65536) - 8 * 65536, $urandom_range(0, 16 * 65536)
			- 8 * 65536, 3 * UNIT, $urandom_range(0, 2 * 2 ** 30) - 2 ** 30,
			ONE_N / 2, -ONE_N / 3);
		random_phase();
		set_ray(rcbi_pkg::PARAM_MAX, rcbi_pkg::PARAM_MAX, rcbi_pkg::PARAM_MAX,
			rcbi_pkg::PARAM_MIN, rcbi_pkg::PARAM_MIN, rcbi_pkg::PARAM_MIN);
		random_phase();
		set_ray(UNIT, -UNIT, 0, 0, 0, 0);
		random_phase();
		sender_calm = 1;
		set_ray(rcbi_pkg::PARAM_MIN, rcbi_pkg::PARAM_MIN, rcbi_pkg::PARAM_MIN,
			rcbi_pkg::PARAM_MAX, rcbi_pkg::PARAM_MAX, rcbi_pkg::PARAM_MAX);
		random_phase();
		sender_calm = 0;
		set_ray(-2 * UNIT, UNIT / 2, UNIT, -ONE_N, ONE_N / 4, ONE_N / 8);
		random_phase();

		in_valid <= 1'b0;
		while (hits_sb.pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d planes in %0d solids over six ray settings, %0d hits, %0d mismatches",
			hits_sb.planes, hits_sb.results, hits_sb.hits, hits_sb.mismatches);
		if (hits_sb.mismatches == 0)
			$display("ray_convex_brush_intersect_tb: PASS");
		else
			$display("ray_convex_brush_intersect_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
